>>> hw/rtl/chsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chsp_pkg
// Shared types and constants for the chunk-size line parser.
// ----------------------------------------------------------------------------
package chsp_pkg;

	localparam int unsigned CountW = 16;
	localparam int unsigned SizeW  = 64;
	localparam int unsigned ByteW  = 8;

	localparam logic [CountW-1:0] MaxLineReset = 16'd1024;
	localparam logic [ByteW-1:0]  ChCr         = 8'h0D;
	localparam logic [ByteW-1:0]  ChLf         = 8'h0A;

	// Parser position within the size line
	typedef enum logic [2:0] {
		ST_START = 3'd0,
		ST_SIZE  = 3'd1,
		ST_NL1   = 3'd2,
		ST_NL2   = 3'd3,
		ST_NL3   = 3'd4
	} parse_state_t;

	typedef enum logic [1:0] {
		STATUS_MORE = 2'd0,
		STATUS_OK   = 2'd1,
		STATUS_FAIL = 2'd2
	} status_t;

	// Request function codes
	localparam logic FuncData  = 1'b0;
	localparam logic FuncReset = 1'b1;

	// Architectural parser state carried between beats
	typedef struct packed {
		parse_state_t      state;
		logic [CountW-1:0] count;
		logic [SizeW-1:0]  size;
	} parser_ctx_t;

endpackage

>>> hw/rtl/chsp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chsp_step
// Per-beat update of the parser: line limit, hex accumulation and CRLF steps.
// ----------------------------------------------------------------------------
module chsp_step import chsp_pkg::*; (
	input  logic              func,
	input  logic [ByteW-1:0]  data_byte,
	input  logic [CountW-1:0] max_line_length,
	input  parser_ctx_t       ctx,
	output parser_ctx_t       ctx_next,
	output status_t           status
);

	logic              is_hex;
	logic [3:0]        digit;
	logic [CountW:0]   count_inc;
	logic              over_limit;

	// Decode a hex digit of either case
	always_comb begin
		is_hex = 1'b1;
		digit  = 4'd0;
		if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
			digit = data_byte[3:0];
		end else if ((data_byte >= 8'h61 && data_byte <= 8'h66) ||
		             (data_byte >= 8'h41 && data_byte <= 8'h46)) begin
			digit = 4'(data_byte[2:0] + 3'd1) + 4'd8;
		end else begin
			is_hex = 1'b0;
		end
	end

	// Count with one spare bit so the limit test sees past saturation
	assign count_inc  = {1'b0, ctx.count} + (CountW+1)'(1);
	assign over_limit = count_inc > {1'b0, max_line_length};

	// Advance the parser
	always_comb begin
		ctx_next = ctx;
		status   = STATUS_FAIL;
		if (func == FuncReset) begin
			ctx_next.state = ST_START;
			ctx_next.count = '0;
			ctx_next.size  = '0;
			status         = STATUS_MORE;
		end else begin
			ctx_next.count = count_inc[CountW] ? '1 : count_inc[CountW-1:0];
			if (!over_limit) begin
				unique case (ctx.state)
					ST_START: begin
						if (is_hex) begin
							ctx_next.size  = SizeW'(digit);
							ctx_next.state = ST_SIZE;
							status         = STATUS_MORE;
						end else if (data_byte == ChCr || data_byte == ChLf) begin
							status = STATUS_MORE;
						end
					end
					ST_SIZE: begin
						if (is_hex) begin
							ctx_next.size = {ctx.size[SizeW-5:0], digit};
							status        = STATUS_MORE;
						end else if (data_byte == ChCr) begin
							ctx_next.state = ST_NL1;
							status         = STATUS_MORE;
						end
					end
					ST_NL1: begin
						if (data_byte == ChLf) begin
							if (ctx.size != '0) begin
								status = STATUS_OK;
							end else begin
								ctx_next.state = ST_NL2;
								status         = STATUS_MORE;
							end
						end
					end
					ST_NL2: begin
						if (data_byte == ChCr) begin
							ctx_next.state = ST_NL3;
							status         = STATUS_MORE;
						end
					end
					ST_NL3: begin
						if (data_byte == ChLf) begin
							status = STATUS_OK;
						end
					end
					default: begin
						status = STATUS_FAIL;
					end
				endcase
			end
		end
	end

endmodule

>>> hw/rtl/http_chunk_size_line_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunk_size_line_parser_top
// Chunk-size line parser for HTTP chunked transfer coding, one byte a beat.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready) carries func and data_byte. func 0
//   feeds a byte of the size line; func 1 restarts the parser.
//   Response channel (rsp_valid/rsp_ready) returns exactly one beat per
//   request: status (0 more, 1 ok, 2 fail) and chunk_size so far.
//   cfg_we/cfg_wdata set max_line_length; write only while the block is idle.
// Pipeline and throughput:
//   A request beat is captured in the input register, evaluated by the
//   step logic and lands in the response register, from which it is
//   offered. One beat per cycle is sustained while the receiver takes
//   responses; the parser state updates as a beat moves from the input
//   register to the response register, so consecutive bytes see each
//   other's effect.
// Reset:
//   arst_n clears both pipeline stages, the parser state, and sets the line
//   limit to 1024.
// Stall:
//   A held response keeps its beat; one more request is absorbed by the
//   input register, after which req_ready drops until the response is taken.
// ----------------------------------------------------------------------------
module http_chunk_size_line_parser_top import chsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic              func,
	input  logic [ByteW-1:0]  data_byte,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [1:0]        status,
	output logic [SizeW-1:0]  chunk_size,
	input  logic              cfg_we,
	input  logic [CountW-1:0] cfg_wdata
);

	logic              valid_s1;
	logic              func_s1;
	logic [ByteW-1:0]  byte_s1;
	logic              valid_s2;
	status_t           status_s2;
	logic [SizeW-1:0]  size_s2;
	logic [CountW-1:0] max_len_q;
	parser_ctx_t       ctx_q;
	parser_ctx_t       ctx_next;
	status_t           step_status;
	logic              load_s2;
	logic              adv_s1;

	assign load_s2   = !valid_s2 || rsp_ready;
	assign adv_s1    = valid_s1 && load_s2;
	assign req_ready = !valid_s1 || load_s2;

	// Line limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MaxLineReset;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	// Input register: take a beat whenever the stage is free or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			func_s1 <= func;
			byte_s1 <= data_byte;
		end
	end

	chsp_step u_step (
		.func            (func_s1),
		.data_byte       (byte_s1),
		.max_line_length (max_len_q),
		.ctx             (ctx_q),
		.ctx_next        (ctx_next),
		.status          (step_status)
	);

	// Parser state: advance once per beat leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.state <= ST_START;
			ctx_q.count <= '0;
			ctx_q.size  <= '0;
		end else if (adv_s1) begin
			ctx_q <= ctx_next;
		end
	end

	// Response register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_s2 <= step_status;
			size_s2   <= ctx_next.size;
		end
	end

	assign rsp_valid  = valid_s2;
	assign status     = status_s2;
	assign chunk_size = size_s2;

endmodule

>>> hw/rtl/chsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chsp_checker
// Port-level checks for the chunk-size line parser, bound to the top level.
// ----------------------------------------------------------------------------
module chsp_checker import chsp_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [1:0]        status,
	input logic [SizeW-1:0]  chunk_size
);

	// Hold a stalled response beat
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(chunk_size))
		else $error("stalled response beat changed");

	// Only the three defined status codes appear
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == STATUS_MORE || status == STATUS_OK ||
		               status == STATUS_FAIL))
		else $error("undefined status code");

	// Back-pressure only when both stages are full and the receiver stalls
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request stalled without a stalled response");

	// A fresh response follows an accepted request through the input and response registers
	a_rsp_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
		else $error("response appeared without a matching request");

endmodule

bind http_chunk_size_line_parser_top chsp_checker u_chsp_checker (.*);

>>> verif/tb_http_chunk_size_line_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_chunk_size_line_parser_top
// Self-checking bench for the chunk-size line parser.
// A local parser model predicts status and chunk size for every accepted
// request beat. A checker compares each response beat with the oldest
// prediction. Directed lines, line-limit corners, a long response hold-off
// and a random mix of good and broken lines are applied in turn, under
// bursty request traffic and a patterned response stall.
// ----------------------------------------------------------------------------
module tb_http_chunk_size_line_parser_top;
	import chsp_pkg::*;

	localparam int unsigned HalfPeriod  = 6;
	localparam int unsigned ResetCycles = 6;
	localparam int unsigned DrainCycles = 6;
	localparam int unsigned HoldCycles  = 400;
	// No-progress limit: several times the longest correct quiet stretch (the hold-off)
	localparam int unsigned WatchLimit  = 4000;
	localparam int unsigned ReportCap   = 40;
	localparam int unsigned PhaseBeats  = 210;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_RANDOM,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	typedef struct {
		status_t          st;
		logic [SizeW-1:0] chunk;
	} line_reply_t;

	// Bytes that sit just outside the hex ranges, the extremes 00 and FF, plus the line terminators
	localparam logic [ByteW-1:0] NearMiss [10] = '{
		8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67, 8'h00, 8'hFF, 8'h0D, 8'h0A
	};

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_ready;
	logic              func;
	logic [ByteW-1:0]  data_byte;
	logic              rsp_valid;
	logic              rsp_ready;
	logic [1:0]        status;
	logic [SizeW-1:0]  chunk_size;
	logic              cfg_we;
	logic [CountW-1:0] cfg_wdata;

	// Parser model state and line limit
	parse_state_t      line_state;
	logic [CountW-1:0] line_count;
	logic [SizeW-1:0]  line_size;
	logic [CountW-1:0] line_limit;

	line_reply_t expected_replies [$];
	line_reply_t want;

	int unsigned errors;
	int unsigned beats_sent;
	int unsigned beats_checked;
	int unsigned limits_written;
	int unsigned idle_cycles;
	int unsigned burst_left;
	bit          tx_gaps;
	int unsigned hold_asks;
	int unsigned hold_seen;
	rx_mode_t    rx_mode;
	int unsigned rx_seg_left;
	int unsigned rx_tick;

	http_chunk_size_line_parser_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.func       (func),
		.data_byte  (data_byte),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.status     (status),
		.chunk_size (chunk_size),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #(HalfPeriod) clk = ~clk;
	end

	// Advance the parser model by one request and return the status it answers
	function automatic status_t advance_parser(input logic f, input logic [ByteW-1:0] b);
		logic [CountW:0] next_count;
		logic            is_hex;
		logic [3:0]      digit;
		status_t         st;
		if (f == FuncReset) begin
			line_state = ST_START;
			line_count = '0;
			line_size  = '0;
			return STATUS_MORE;
		end
		// '0'..'9', then 'a'..'f' or 'A'..'F' (low nibble 1..6 plus nine)
		is_hex = 1'b0;
		digit  = '0;
		if (b >= 8'h30 && b <= 8'h39) begin
			is_hex = 1'b1;
			digit  = b[3:0];
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			is_hex = 1'b1;
			digit  = b[3:0] + 4'd9;
		end
		next_count = {1'b0, line_count} + 1'b1;
		line_count = next_count[CountW] ? '1 : next_count[CountW-1:0];
		// Limit test uses the unsaturated count
		if (next_count > {1'b0, line_limit})
			return STATUS_FAIL;
		st = STATUS_FAIL;
		case (line_state)
			ST_START: begin
				if (is_hex) begin
					line_size  = SizeW'(digit);
					line_state = ST_SIZE;
					st = STATUS_MORE;
				end else if (b == ChCr || b == ChLf) begin
					st = STATUS_MORE;
				end
			end
			ST_SIZE: begin
				if (is_hex) begin
					line_size = (line_size << 4) + SizeW'(digit);
					st = STATUS_MORE;
				end else if (b == ChCr) begin
					line_state = ST_NL1;
					st = STATUS_MORE;
				end
			end
			ST_NL1: begin
				if (b == ChLf) begin
					if (line_size != '0) begin
						st = STATUS_OK;
					end else begin
						line_state = ST_NL2;
						st = STATUS_MORE;
					end
				end
			end
			ST_NL2: begin
				if (b == ChCr) begin
					line_state = ST_NL3;
					st = STATUS_MORE;
				end
			end
			ST_NL3: begin
				if (b == ChLf)
					st = STATUS_OK;
			end
			default: st = STATUS_FAIL;
		endcase
		return st;
	endfunction

	function automatic logic [ByteW-1:0] odd_byte();
		if ($urandom_range(0, 1) == 0)
			return ByteW'($urandom_range(0, 255));
		return NearMiss[$urandom_range(0, 9)];
	endfunction

	// Offer one request beat, hold it until accepted, then record the prediction
	task automatic send_beat(input logic f, input logic [ByteW-1:0] b);
		int unsigned gap;
		line_reply_t rep;
		if (tx_gaps && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 15) : $urandom_range(0, 3);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left != 0)
			burst_left--;
		req_valid <= 1'b1;
		func      <= f;
		data_byte <= b;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		rep.st    = advance_parser(f, b);
		rep.chunk = line_size;
		expected_replies.push_back(rep);
		beats_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(FuncData, s[i]);
	endtask

	// Drop valid and wait until every predicted beat has come back
	task automatic drain_replies();
		req_valid <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_limit(input logic [CountW-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we     <= 1'b0;
		line_limit  = v;
		limits_written++;
	endtask

	// One size line: optional restart, leading CR/LF, digits, terminators,
	// now and then with a byte replaced or dropped
	task automatic send_random_line();
		logic [ByteW-1:0] text [$];
		int unsigned      ndig;
		int unsigned      v;
		int unsigned      pick;
		bit               zero;
		if ($urandom_range(0, 7) != 0)
			send_beat(FuncReset, ByteW'($urandom_range(0, 255)));
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 2))
				text.push_back(($urandom_range(0, 1) == 0) ? ChCr : ChLf);
		end
		ndig = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 6);
		zero = ($urandom_range(0, 4) == 0);
		repeat (ndig) begin
			v = zero ? 0 : $urandom_range(0, 15);
			if (v < 10)
				text.push_back(ByteW'(8'h30 + v));
			else
				text.push_back(ByteW'((($urandom_range(0, 1) == 0) ? 8'h41 : 8'h61) + v - 10));
		end
		text.push_back(ChCr);
		text.push_back(ChLf);
		if (zero || $urandom_range(0, 3) == 0) begin
			text.push_back(ChCr);
			text.push_back(ChLf);
		end
		if ($urandom_range(0, 3) == 0)
			text.push_back(ChLf);
		pick = $urandom_range(0, 5);
		if (pick == 0)
			text[$urandom_range(0, text.size() - 1)] = odd_byte();
		else if (pick == 1)
			text.delete($urandom_range(0, text.size() - 1));
		foreach (text[i])
			send_beat(FuncData, text[i]);
	endtask

	task automatic test_directed_lines();
		send_beat(FuncReset, 8'hFF);
		send_text("\015\012");           // leading CR LF skipped
		send_text("0fA9aF");             // digit range ends, both cases
		send_text("\015\012");           // CR LF: ok
		send_text("\012");               // repeated LF: ok again
		send_text("G");                  // unexpected byte
		send_beat(FuncReset, 8'h00);
		send_beat(FuncData, 8'hFF);      // junk before any digit
		send_beat(FuncReset, 8'h55);
		send_text("1x\015\012");         // unexpected byte leaves state alone
		send_beat(FuncReset, 8'hAA);
		send_text("0\015\012\015\012");  // zero size needs the empty line
		drain_replies();
	endtask

	task automatic test_line_limits();
		write_limit(16'd0);
		send_text("5\015");              // limit of zero: every byte fails
		send_beat(FuncReset, 8'h00);
		drain_replies();
		write_limit(16'd1);
		send_text("5\015");              // second byte over the limit
		send_beat(FuncReset, 8'h00);
		drain_replies();
		write_limit(16'd3);
		send_text("a\015\012\012");      // ok on the last allowed byte, then fail
		send_beat(FuncReset, 8'h00);
		drain_replies();
	endtask

	// Hold the response side off while the sender keeps pushing
	task automatic test_backpressure();
		tx_gaps = 1'b0;
		write_limit(MaxLineReset);
		hold_asks <= hold_asks + 1;
		send_beat(FuncReset, 8'h00);
		send_text("7f\015\012");
		repeat (16)
			send_beat(FuncData, odd_byte());
		drain_replies();
	endtask

	task automatic test_random_lines();
		int unsigned      target;
		logic [CountW-1:0] lim;
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: lim = MaxLineReset;
				1: lim = '1;
				2: lim = CountW'($urandom_range(1, 6));
				3: lim = '0;
				4: lim = CountW'($urandom_range(7, 30));
				default: lim = CountW'($urandom_range(31, 65534));
			endcase
			write_limit(lim);
			tx_gaps = (p != 1);
			target = beats_sent + PhaseBeats;
			while (beats_sent < target) begin
				if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(1, 6))
						send_beat(($urandom_range(0, 5) == 0) ? FuncReset : FuncData, odd_byte());
				end else begin
					send_random_line();
				end
			end
			drain_replies();
		end
	endtask

	// Response ready: random segments of patterns, plus a long hold on request
	initial begin
		rsp_ready   = 1'b0;
		rx_mode     = RX_OPEN;
		rx_seg_left = 0;
		rx_tick     = 0;
		hold_seen   = 0;
		forever begin
			@(posedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				rsp_ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
			end
			if (rx_seg_left == 0) begin
				rx_mode     = rx_mode_t'($urandom_range(0, 3));
				rx_seg_left = $urandom_range(4, 60);
			end
			rx_seg_left--;
			rx_tick++;
			case (rx_mode)
				RX_OPEN:     rsp_ready <= 1'b1;
				RX_RANDOM:   rsp_ready <= ($urandom_range(0, 1) == 1);
				RX_SPARSE:   rsp_ready <= ($urandom_range(0, 3) == 0);
				default:     rsp_ready <= (rx_tick % 3 == 0);
			endcase
		end
	end

	// Compare each response beat with the oldest prediction; watch for no progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WatchLimit) begin
				$display("watchdog: no beat moved for %0d cycles", WatchLimit);
				$display("** http_chunk_size_line_parser_top: FAILED **");
				$finish;
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_replies.size() == 0) begin
					errors++;
					$error("response beat with nothing outstanding");
				end else begin
					want = expected_replies.pop_front();
					beats_checked++;
					if (status !== 2'(want.st)) begin
						errors++;
						if (errors <= ReportCap)
							$error("status: expected %0d, got %0d", want.st, status);
					end
					if (chunk_size !== want.chunk) begin
						errors++;
						if (errors <= ReportCap)
							$error("chunk_size: expected %h, got %h", want.chunk, chunk_size);
					end
				end
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		req_valid      = 1'b0;
		func           = FuncData;
		data_byte      = '0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		errors         = 0;
		beats_sent     = 0;
		beats_checked  = 0;
		limits_written = 0;
		idle_cycles    = 0;
		burst_left     = 0;
		tx_gaps        = 1'b1;
		hold_asks      = 0;
		line_state     = ST_START;
		line_count     = '0;
		line_size      = '0;
		line_limit     = MaxLineReset;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_lines();
		test_line_limits();
		test_backpressure();
		test_random_lines();

		$display("Run covered %0d request beats, %0d responses checked, %0d limit writes,",
			beats_sent, beats_checked, limits_written);
		$display("with directed lines, limit corners, a long hold-off and random lines.");
		if (errors == 0)
			$display("** http_chunk_size_line_parser_top: PASSED **");
		else
			$display("** http_chunk_size_line_parser_top: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/chsp_pkg.sv
hw/rtl/chsp_step.sv
hw/rtl/http_chunk_size_line_parser_top.sv
hw/rtl/chsp_checker.sv
verif/tb_http_chunk_size_line_parser_top.sv
